@@ rtl/pba_pkg.sv @@
// Package for the identifier allocator: sizes and item types.
package pba_pkg;

    localparam int ID_COUNT  = 256;
    localparam int WORD_W    = 32;
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int WORDS     = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int WADDR_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int ID_FULL_W = WADDR_W + BIT_W;
    localparam int STEP_W    = $clog2(WORDS + 1);
    localparam int REL_W     = 16;
    localparam int GRANT_W   = 8;

    localparam logic ACT_ALLOC   = 1'b0;
    localparam logic ACT_RELEASE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [REL_W-1:0] release_id;
    } req_t;

    typedef struct packed {
        logic [GRANT_W-1:0] granted_id;
        logic               success;
    } rsp_t;

endpackage

@@ rtl/pid_bitmap_allocator.sv @@
// Identifier allocator: used-bitmap in a word memory with a next-fit pointer.
//
//   channel   dir   handshake          payload
//   s_        in    s_valid / s_ready  pba_pkg::req_t (action, release_id)
//   m_        out   m_valid / m_ready  pba_pkg::rsp_t (granted_id, success)
//
// One item at a time. The bitmap is read one 32-bit word per cycle from the
// pointer's word; an allocate reads on, wrapping, and reads the pointer's word
// again for the bits below the pointer, stopping at the first free bit.
// A release reads only its id's word; an out-of-range release skips the memory.
// Reset marks every memory row invalid; an invalid row reads as its reset
// value, so no clearing pass is needed. A stalled m_ready holds the result
// and keeps the next item's result waiting in the result register.
module pid_bitmap_allocator (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pba_pkg::req_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pba_pkg::rsp_t  m_data
);
    import pba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic                  op_rel_reg, op_rel_next;
    logic [ID_FULL_W-1:0]  rel_id_reg, rel_id_next;
    logic [ID_FULL_W-1:0]  ptr_reg, ptr_next;
    logic [WADDR_W-1:0]    issue_word_reg, issue_word_next;
    logic [STEP_W-1:0]     issue_step_reg, issue_step_next;
    logic                  issuing_reg, issuing_next;
    logic                  eval_vld_reg, eval_vld_next;
    logic [WADDR_W-1:0]    eval_word_reg, eval_word_next;
    logic [STEP_W-1:0]     eval_step_reg, eval_step_next;
    rsp_t                  res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    rsp_t                  m_data_reg, m_data_next;
    logic [WORDS-1:0]      row_valid_reg, row_valid_next;

    logic [WORD_W-1:0]     ram [WORDS];
    logic [WORD_W-1:0]     rd_data_reg;
    logic                  rd_en;
    logic                  wr_en;
    logic [WORD_W-1:0]     wr_data;

    logic                  rel_in_range;
    logic [ID_FULL_W-1:0]  acc_id;
    logic [STEP_W-1:0]     last_step;
    logic [WORD_W-1:0]     word_eff;
    logic [WORD_W-1:0]     scan_mask;
    logic [WORD_W-1:0]     free_bits;
    logic [WORD_W-1:0]     first_free;
    logic [BIT_W-1:0]      free_idx;
    logic [ID_FULL_W-1:0]  found_id;
    logic [ID_FULL_W+GRANT_W-1:0] found_wide;
    logic [BIT_W-1:0]      ptr_bit;
    logic [BIT_W-1:0]      rel_bit;
    logic                  out_free;

    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign rel_in_range = ({1'b0, s_data.release_id} < (REL_W + 1)'(ID_COUNT));
    assign acc_id       = (s_data.action == ACT_RELEASE) ?
                          s_data.release_id[ID_FULL_W-1:0] : ptr_reg;
    assign last_step    = op_rel_reg ? '0 : STEP_W'(WORDS);
    assign ptr_bit      = ptr_reg[BIT_W-1:0];
    assign rel_bit      = rel_id_reg[BIT_W-1:0];

    assign rd_en = (state_reg == S_SCAN) && issuing_reg;

    always_comb begin
        if (row_valid_reg[eval_word_reg]) begin
            word_eff = rd_data_reg;
        end else begin
            word_eff = (eval_word_reg == '0) ? WORD_W'(1) : '0;
        end
    end

    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            scan_mask[j] = ({1'b0, eval_word_reg, BIT_W'(j)} < (ID_FULL_W + 1)'(ID_COUNT));
            if (eval_step_reg == '0) begin
                scan_mask[j] = scan_mask[j] && (BIT_W'(j) >= ptr_bit);
            end else if (eval_step_reg == STEP_W'(WORDS)) begin
                scan_mask[j] = scan_mask[j] && (BIT_W'(j) < ptr_bit);
            end
        end
    end

    assign free_bits  = ~word_eff & scan_mask;
    assign first_free = free_bits & (~free_bits + WORD_W'(1));

    always_comb begin
        free_idx = '0;
        for (int j = 0; j < WORD_W; j++) begin
            if (first_free[j]) begin
                free_idx = free_idx | BIT_W'(j);
            end
        end
    end

    assign found_id   = {eval_word_reg, free_idx};
    assign found_wide = {{GRANT_W{1'b0}}, found_id};

    always_comb begin
        state_next      = state_reg;
        op_rel_next     = op_rel_reg;
        rel_id_next     = rel_id_reg;
        ptr_next        = ptr_reg;
        issue_word_next = issue_word_reg;
        issue_step_next = issue_step_reg;
        issuing_next    = issuing_reg;
        eval_vld_next   = 1'b0;
        eval_word_next  = eval_word_reg;
        eval_step_next  = eval_step_reg;
        res_next        = res_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        row_valid_next  = row_valid_reg;
        wr_en           = 1'b0;
        wr_data         = word_eff;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_rel_next = (s_data.action == ACT_RELEASE);
                    rel_id_next = s_data.release_id[ID_FULL_W-1:0];
                    res_next.granted_id = s_data.release_id[GRANT_W-1:0];
                    res_next.success    = 1'b0;
                    issue_word_next     = acc_id[ID_FULL_W-1:BIT_W];
                    issue_step_next     = '0;
                    if (s_data.action == ACT_RELEASE && !rel_in_range) begin
                        state_next = S_RESP;
                    end else begin
                        issuing_next = 1'b1;
                        state_next   = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (issuing_reg) begin
                    eval_vld_next  = 1'b1;
                    eval_word_next = issue_word_reg;
                    eval_step_next = issue_step_reg;
                    if (issue_step_reg == last_step) begin
                        issuing_next = 1'b0;
                    end else begin
                        issue_step_next = issue_step_reg + STEP_W'(1);
                        issue_word_next = (issue_word_reg == WADDR_W'(WORDS - 1)) ?
                                          '0 : issue_word_reg + WADDR_W'(1);
                    end
                end
                if (eval_vld_reg) begin
                    if (op_rel_reg) begin
                        wr_en      = 1'b1;
                        wr_data    = word_eff & ~(WORD_W'(1) << rel_bit);
                        res_next.success = 1'b1;
                        state_next = S_RESP;
                    end else if (free_bits != '0) begin
                        wr_en      = 1'b1;
                        wr_data    = word_eff | first_free;
                        ptr_next   = (found_id == ID_FULL_W'(ID_COUNT - 1)) ?
                                     '0 : found_id + ID_FULL_W'(1);
                        res_next.granted_id = found_wide[GRANT_W-1:0];
                        res_next.success    = 1'b1;
                        state_next = S_RESP;
                    end else if (eval_step_reg == STEP_W'(WORDS)) begin
                        res_next.granted_id = '0;
                        res_next.success    = 1'b0;
                        state_next = S_RESP;
                    end
                    if (wr_en) begin
                        row_valid_next[eval_word_reg] = 1'b1;
                    end
                    if (state_next == S_RESP) begin
                        issuing_next  = 1'b0;
                        eval_vld_next = 1'b0;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ram[eval_word_reg] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= ram[issue_word_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            ptr_reg       <= ID_FULL_W'(1);
            issuing_reg   <= 1'b0;
            eval_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            row_valid_reg <= '0;
        end else begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            issuing_reg   <= issuing_next;
            eval_vld_reg  <= eval_vld_next;
            m_valid_reg   <= m_valid_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_rel_reg     <= op_rel_next;
        rel_id_reg     <= rel_id_next;
        issue_word_reg <= issue_word_next;
        issue_step_reg <= issue_step_next;
        eval_word_reg  <= eval_word_next;
        eval_step_reg  <= eval_step_next;
        res_reg        <= res_next;
        m_data_reg     <= m_data_next;
    end

endmodule
